// ===== design/rbd_pkg.sv =====
// Shared types and defaults for the ring buffer deque.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

	// Default geometry
	localparam int RBD_DEPTH      = 16;
	localparam int RBD_ELEM_WIDTH = 32;

	// Fixed field widths on the stream ports
	localparam int ACTION_W    = 3;
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 4;
	localparam int STATUS_W    = 2;
	localparam int OCCUPANCY_W = 5;

	// Action codes carried in tuser on the input side
	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_GET        = 3'd4,
		ACT_SET        = 3'd5,
		ACT_CLEAR      = 3'd6
	} rbd_action_t;

	// Status codes carried in tuser on the output side
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} rbd_status_t;

endpackage : rbd_pkg

`default_nettype wire

// ===== design/rbd_store.sv =====
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rbd_store
	import rbd_pkg::*;
#(
	parameter int DEPTH      = RBD_DEPTH,
	parameter int ELEM_WIDTH = RBD_ELEM_WIDTH,
	localparam int PW        = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [PW-1:0]         wr_addr,
	input  wire logic [ELEM_WIDTH-1:0] wr_data,
	input  wire logic                  rd_en,
	input  wire logic [PW-1:0]         rd_addr,
	output logic      [ELEM_WIDTH-1:0] rd_data_q
);

	logic [ELEM_WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule : rbd_store

`default_nettype wire

// ===== design/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: action decode, pointers and result stage.
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   elem_value[31:0], logical_index[35:32]      action[2:0]
//  m_axis    out  read_value[31:0], occupancy[36:32]          status[1:0]
//
// One action is accepted per cycle while the result stage can drain; its result beat is
// registered first in the entry store read and the result stage, then in the output register.
// Pointers and count update on the accept edge, so back-to-back actions on the
// same entry see each other without forwarding.
// Reset clears pointers, count and valid flags and holds input off until the first edge after.
// A stalled output holds its beat and the input stalls once the result stage fills.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_deque
	import rbd_pkg::*;
#(
	parameter int DEPTH      = RBD_DEPTH,
	parameter int ELEM_WIDTH = RBD_ELEM_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // elem_value[31:0], logical_index[35:32], zero
	input  wire logic [2:0]  s_axis_tuser,  // action[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [39:0] m_axis_tdata,  // read_value[31:0], occupancy[36:32], zero
	output logic      [1:0]  m_axis_tuser   // status[1:0]
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = (PW + 1 > INDEX_W) ? PW + 1 : INDEX_W;

	typedef struct packed {
		logic        valid;
		rbd_status_t status;
		logic        rd_flag;
	} rbd_ctrl_t;

	// Pointer and count state
	logic [PW-1:0] front_q;
	logic [PW-1:0] rear_q;
	logic [CW-1:0] count_q;

	// Next state and store access
	logic [PW-1:0]         front_n;
	logic [PW-1:0]         rear_n;
	logic [CW-1:0]         count_n;
	logic                  wr_en;
	logic [PW-1:0]         wr_addr;
	logic                  rd_en;
	logic [PW-1:0]         rd_addr;
	logic                  rd_flag;
	rbd_status_t           status;
	logic [ELEM_WIDTH-1:0] wr_data;
	logic [ELEM_WIDTH-1:0] rd_data_q;

	// Decoded input fields
	rbd_action_t        act;
	logic [VALUE_W-1:0] elem_value;
	logic [INDEX_W-1:0] logical_index;

	// Helpers
	logic          full;
	logic          empty;
	logic          in_range;
	logic [SW-1:0] slot_sum;
	logic [PW-1:0] slot;
	logic [PW-1:0] front_up;
	logic [PW-1:0] front_dn;
	logic [PW-1:0] rear_up;
	logic [PW-1:0] rear_dn;

	// Pipeline and output registers
	rbd_ctrl_t             ctrl_s1;
	logic [CW-1:0]         occ_s1;
	logic                  out_valid_q;
	rbd_status_t           out_status_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic [OCCUPANCY_W-1:0] out_occ_q;
	logic                  ready_q;

	logic accept;
	logic advance;

	assign act           = rbd_action_t'(s_axis_tuser);
	assign elem_value    = s_axis_tdata[VALUE_W-1:0];
	assign logical_index = s_axis_tdata[VALUE_W+INDEX_W-1:VALUE_W];
	assign wr_data       = ELEM_WIDTH'(elem_value);

	// Hold the input off while in reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	// Handshake: the result stage drains into the output register
	assign advance       = ctrl_s1.valid && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = ready_q && (!ctrl_s1.valid || advance);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Pointer steps with wrap
	assign front_up = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);
	assign front_dn = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
	assign rear_up  = (rear_q == PW'(DEPTH - 1)) ? '0 : rear_q + PW'(1);
	assign rear_dn  = (rear_q == '0) ? PW'(DEPTH - 1) : rear_q - PW'(1);

	// Physical slot of a logical index; for an in-range index the sum stays below twice the depth
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = SW'(logical_index) < SW'(count_q);
	assign slot_sum = SW'(front_q) + SW'(logical_index);
	assign slot     = (slot_sum >= SW'(DEPTH)) ? PW'(slot_sum - SW'(DEPTH)) : PW'(slot_sum);

	// Decode the action into store access and next pointers
	always_comb begin
		front_n = front_q;
		rear_n  = rear_q;
		count_n = count_q;
		wr_en   = 1'b0;
		wr_addr = slot;
		rd_en   = 1'b0;
		rd_addr = slot;
		rd_flag = 1'b0;
		status  = ST_OK;
		unique case (act)
			ACT_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					front_n = front_dn;
					wr_en   = accept;
					wr_addr = front_dn;
					count_n = count_q + CW'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					rear_n  = rear_up;
					wr_en   = accept;
					wr_addr = rear_q;
					count_n = count_q + CW'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					front_n = front_up;
					rd_en   = accept;
					rd_addr = front_q;
					rd_flag = 1'b1;
					count_n = count_q - CW'(1);
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					rear_n  = rear_dn;
					rd_en   = accept;
					rd_addr = rear_dn;
					rd_flag = 1'b1;
					count_n = count_q - CW'(1);
				end
			end
			ACT_GET: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					rd_en   = accept;
					rd_flag = 1'b1;
				end
			end
			ACT_SET: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					wr_en = accept;
				end
			end
			ACT_CLEAR: begin
				front_n = '0;
				rear_n  = '0;
				count_n = '0;
			end
			default: begin
			end
		endcase
	end

	// Hold pointers and count; advance them on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_n;
			rear_q  <= rear_n;
			count_q <= count_n;
		end
	end

	rbd_store #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_rbd_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data_q)
	);

	// Result stage: wait for the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (accept) begin
			ctrl_s1 <= '{valid: 1'b1, status: status, rd_flag: rd_flag};
		end else if (advance) begin
			ctrl_s1.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			occ_s1 <= count_n;
		end
	end

	// Output register: hold while stalled, load from the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_status_q <= ctrl_s1.status;
			out_value_q  <= ctrl_s1.rd_flag ? VALUE_W'(rd_data_q) : '0;
			out_occ_q    <= OCCUPANCY_W'(occ_s1);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {3'b000, out_occ_q, out_value_q};

endmodule : ring_buffer_deque

`default_nettype wire

// ===== design/rbd_checker.sv =====
// Port-level checks on the ring buffer deque, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rbd_checker
	import rbd_pkg::*;
#(
	parameter int DEPTH = RBD_DEPTH
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	logic out_beat;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// A refused action returns no data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[31:0] == '0))
		else $error("error beat carries read data");

	// Full on push only when every entry is taken
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && (m_axis_tuser == ST_FULL) |-> (m_axis_tdata[36:32] == 5'(DEPTH)))
		else $error("full reported below capacity");

	// Empty on pop only when nothing is held
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && (m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata[36:32] == '0))
		else $error("empty reported with entries held");

	// An accepted action yields its result only through the result stage and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
		else $error("result beat without a preceding action");

endmodule : rbd_checker

bind ring_buffer_deque rbd_checker #(
	.DEPTH (DEPTH)
) u_rbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking stream testbench for the ring buffer deque with its scoreboard class.
`timescale 1ns / 1ps

import rbd_pkg::*;

typedef struct packed {
	rbd_status_t                status;
	logic [VALUE_W-1:0]         read_value;
	logic [OCCUPANCY_W-1:0]     occupancy;
} deque_result_t;

// Mirror of the deque contents; predicts one result beat per accepted action
class deque_scoreboard;
	localparam int PTR_W = $clog2(RBD_DEPTH);

	logic [RBD_ELEM_WIDTH-1:0] slots [RBD_DEPTH];
	logic [PTR_W-1:0]          head_slot;
	logic [PTR_W-1:0]          tail_slot;
	logic [OCCUPANCY_W-1:0]    held;
	deque_result_t             pending_results [$];
	int                        mismatches;
	int                        actions_noted;
	int                        beats_checked;
	int                        status_seen [4];

	function new();
		head_slot = '0;
		tail_slot = '0;
		held = '0;
		mismatches = 0;
		actions_noted = 0;
		beats_checked = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	// Apply one action to the mirror and queue the result it should give
	function void note_action(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
			logic [INDEX_W-1:0] idx);
		deque_result_t    res;
		logic [PTR_W-1:0] slot;
		res.status = ST_OK;
		res.read_value = '0;
		case (act)
			ACT_PUSH_FRONT: begin
				if (held == RBD_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					head_slot = head_slot - 1'b1;
					slots[head_slot] = val;
					held = held + 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				if (held == RBD_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					slots[tail_slot] = val;
					tail_slot = tail_slot + 1'b1;
					held = held + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (held == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.read_value = slots[head_slot];
					head_slot = head_slot + 1'b1;
					held = held - 1'b1;
				end
			end
			ACT_POP_BACK: begin
				if (held == 0) begin
					res.status = ST_EMPTY;
				end else begin
					tail_slot = tail_slot - 1'b1;
					res.read_value = slots[tail_slot];
					held = held - 1'b1;
				end
			end
			ACT_GET, ACT_SET: begin
				if ({1'b0, idx} >= held) begin
					res.status = ST_RANGE;
				end else begin
					slot = head_slot + idx;
					if (act == ACT_GET)
						res.read_value = slots[slot];
					else
						slots[slot] = val;
				end
			end
			ACT_CLEAR: begin
				// contents stay, only the pointers and count go back to zero
				head_slot = '0;
				tail_slot = '0;
				held = '0;
			end
			default: ;
		endcase
		res.occupancy = held;
		pending_results.push_back(res);
		actions_noted++;
	endfunction

	task report_mismatch(string what, deque_result_t got, deque_result_t want);
		$display("MISMATCH %s: got status %0d value %h occupancy %0d, ",
			what, got.status, got.read_value, got.occupancy,
			"wanted status %0d value %h occupancy %0d",
			want.status, want.read_value, want.occupancy);
		mismatches++;
	endtask

	// Compare one result beat against the oldest prediction
	task check_result(deque_result_t got);
		deque_result_t want;
		if (pending_results.size() == 0) begin
			want = '0;
			report_mismatch("beat with nothing outstanding", got, want);
		end else begin
			want = pending_results.pop_front();
			beats_checked++;
			status_seen[want.status]++;
			if (got != want)
				report_mismatch("wrong field", got, want);
		end
	endtask
endclass

module tb;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 500;
	localparam int SEGMENT_ITEMS = 25;

	typedef enum int { MIX_FILL, MIX_DRAIN, MIX_BALANCED } action_mix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // elem_value[31:0], logical_index[35:32], zero
	logic [2:0]  s_axis_tuser = '0;   // action[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // read_value[31:0], occupancy[36:32], zero
	logic [1:0]  m_axis_tuser;        // status[1:0]

	logic        quiet = 1'b0;
	int          cycle_count = 0;
	deque_scoreboard sb;

	ring_buffer_deque DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stall the result side now and then, except in the quiet stretch
	always @(negedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 12);
	end

	// Watch both sides: check result beats, then note accepted actions
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result({rbd_status_t'(m_axis_tuser), m_axis_tdata[31:0],
					m_axis_tdata[36:32]});
			if (s_axis_tvalid && s_axis_tready)
				sb.note_action(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[35:32]);
		end
	end

	// Offer one action beat and hold it until taken; idle one cycle now and then
	task drive_action(input logic [2:0] act, input logic [31:0] val, input logic [3:0] idx);
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, idx, val};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold off the sender until every outstanding result has come back
	task hold_until_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [2:0] pick_action(action_mix_t mix);
		int th [7];
		int r;
		logic [2:0] act;
		case (mix)
			MIX_FILL:  th = '{35, 70, 78, 84, 91, 97, 98};
			MIX_DRAIN: th = '{10, 20, 50, 80, 88, 95, 97};
			default:   th = '{18, 36, 52, 68, 82, 94, 97};
		endcase
		r = $urandom_range(99);
		act = 3'd7;
		for (int i = 6; i >= 0; i--)
			if (r < th[i]) act = i[2:0];
		return act;
	endfunction

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return $urandom;
	endfunction

	initial begin
		action_mix_t mix;
		logic [2:0]  act;
		logic [3:0]  idx;
		int          counted;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: refusals on empty, the unused code, extremes and wrap
		drive_action(ACT_POP_FRONT, 32'h0, 4'd0);
		drive_action(ACT_POP_BACK, 32'h0, 4'd0);
		drive_action(ACT_GET, 32'h0, 4'd0);
		drive_action(ACT_SET, 32'hFFFF_FFFF, 4'd0);
		drive_action(3'd7, 32'hFFFF_FFFF, 4'd15);
		drive_action(ACT_PUSH_BACK, 32'h0000_0000, 4'd15);
		drive_action(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0);
		drive_action(ACT_PUSH_BACK, 32'hA5A5_A5A5, 4'd0);
		drive_action(ACT_GET, 32'h0, 4'd0);
		drive_action(ACT_GET, 32'h0, 4'd2);
		drive_action(ACT_GET, 32'h0, 4'd3);
		drive_action(ACT_SET, 32'h5A5A_5A5A, 4'd1);
		drive_action(ACT_GET, 32'h0, 4'd1);
		drive_action(ACT_GET, 32'h0, 4'd15);
		drive_action(ACT_SET, 32'h1234_5678, 4'd15);
		drive_action(ACT_POP_BACK, 32'h0, 4'd0);
		drive_action(ACT_POP_FRONT, 32'h0, 4'd0);
		drive_action(ACT_POP_FRONT, 32'h0, 4'd0);
		drive_action(ACT_POP_FRONT, 32'h0, 4'd0);
		drive_action(ACT_PUSH_FRONT, 32'h8000_0001, 4'd0);
		drive_action(ACT_CLEAR, 32'h0, 4'd0);
		drive_action(ACT_GET, 32'h0, 4'd0);
		hold_until_drained();

		// Random: segments biased towards filling, draining or neither
		counted = 0;
		mix = MIX_BALANCED;
		while (counted < RANDOM_ITEMS) begin
			if (counted % SEGMENT_ITEMS == 0)
				mix = action_mix_t'($urandom_range(2));
			quiet = (counted >= 200 && counted < 300);
			if (counted == RANDOM_ITEMS / 2)
				hold_until_drained();
			act = pick_action(mix);
			if (sb.held != 0 && $urandom_range(1))
				idx = 4'($urandom_range(sb.held - 1));
			else
				idx = 4'($urandom_range(15));
			drive_action(act, pick_value(), idx);
			if (act != 3'd7)
				counted++;
		end
		quiet = 1'b0;

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d actions and %0d result beats: ",
			sb.actions_noted, sb.beats_checked,
			"%0d full, %0d empty, %0d out of range.",
			sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE]);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
